### rtl/core/ort_pkg.sv
// ----------------------------------------------------------------------------
// ort_pkg: shared definitions of the outstanding request tracker
// Types, codes and constants used by the controller and the datapath.
// ----------------------------------------------------------------------------
package ort_pkg;

  // Default sizes handed to the top level.
  localparam int SLOTS_DEF   = 16;
  localparam int TARGETS_DEF = 64;

  // Transaction id after reset and the ceiling of an outstanding count.
  localparam logic [31:0] TID_RESET = 32'h0000_0123;
  localparam logic [4:0]  OUTS_MAX  = 5'd31;
  localparam logic [31:0] M32       = 32'hFFFF_FFFF;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SLOT_COUNT   = 2'd0;
  localparam logic [1:0] CFG_TARGET_LIMIT = 2'd1;
  localparam logic [1:0] CFG_TARGET_COUNT = 2'd2;

  // Completion status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;

  // Statistic select codes.
  localparam logic [2:0] SEL_SENT    = 3'd0;
  localparam logic [2:0] SEL_OK      = 3'd1;
  localparam logic [2:0] SEL_TIMEOUT = 3'd2;
  localparam logic [2:0] SEL_ERROR   = 3'd3;
  localparam logic [2:0] SEL_MIN     = 3'd4;
  localparam logic [2:0] SEL_MAX     = 3'd5;
  localparam logic [2:0] SEL_AVG     = 3'd6;

  typedef enum logic [1:0] {
    REQ_ISSUE    = 2'd0,
    REQ_COMPLETE = 2'd1,
    REQ_STAT     = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    KIND_ISSUED    = 3'd0,
    KIND_MATCHED   = 3'd1,
    KIND_UNMATCHED = 3'd2,
    KIND_DONE      = 3'd3,
    KIND_STAT      = 3'd4
  } kind_t;

  // Per-target statistics record held in the target memory.
  typedef struct packed {
    logic [4:0]  outs;
    logic [31:0] sent;
    logic [31:0] ok;
    logic [31:0] tmo;
    logic [31:0] err;
    logic [31:0] min_lat;
    logic [31:0] max_lat;
    logic [63:0] total;
    logic [31:0] avg;
  } rec_t;

  typedef enum logic [1:0] {
    ADDR_IDX   = 2'd0,
    ADDR_SLOT  = 2'd1,
    ADDR_QUERY = 2'd2
  } addr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      cap_in;
    logic      slot_clr;
    logic      slot_inc;
    logic      idx_init;
    logic      idx_reduce;
    logic      idx_step;
    logic      mem_rd;
    addr_sel_t addr_sel;
    logic      issue_commit;
    logic      comp_update;
    logic      div_start;
    logic      comp_commit;
    logic      out_unmatched;
    logic      out_done;
    logic      out_stat;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_t req;
    logic slot_end_issue;
    logic slot_end_all;
    logic slot_valid;
    logic tid_match;
    logic idx_ge_nt;
    logic j_end;
    logic qualifies;
    logic div_done;
    logic can_emit;
  } sts_t;

  // Increment that holds at the top of the range.
  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == M32) ? v : v + 32'd1;
  endfunction

endpackage

### rtl/core/ort_div.sv
// ----------------------------------------------------------------------------
// ort_div: radix-2 restoring divider
// Divides a 64-bit total by a 34-bit count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ort_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [33:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy;
  logic [6:0]  cnt;
  logic [63:0] dq;
  logic [33:0] rem;
  logic [33:0] dvs;
  logic [34:0] rem_sh;
  logic [34:0] rem_sub;

  // Shift in the next dividend bit and trial-subtract the divisor.
  assign rem_sh  = {rem, dq[63]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 7'd1;
      if (cnt == 7'd63) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and quotient registers; quotient bits replace dividend bits.
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!rem_sub[34]) begin
        rem <= rem_sub[33:0];
        dq  <= {dq[62:0], 1'b1};
      end else begin
        rem <= rem_sh[33:0];
        dq  <= {dq[62:0], 1'b0};
      end
    end
  end

  assign done     = !busy;
  assign quotient = dq;

endmodule

### rtl/core/ort_ctrl.sv
// ----------------------------------------------------------------------------
// ort_ctrl: sequencing state machine of the outstanding request tracker
// Steps the issue pass, completion and statistics read through the datapath.
// ----------------------------------------------------------------------------
module ort_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ort_pkg::sts_t sts,
  output ort_pkg::cmd_t cmd
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_DISPATCH = 15'h0002,
    S_ISCAN    = 15'h0004,
    S_IREDUCE  = 15'h0008,
    S_IRD      = 15'h0010,
    S_ICHK     = 15'h0020,
    S_IEMIT    = 15'h0040,
    S_IDONE    = 15'h0080,
    S_CSCAN    = 15'h0100,
    S_CUPD     = 15'h0200,
    S_CDIVST   = 15'h0400,
    S_CDIV     = 15'h0800,
    S_CEMIT    = 15'h1000,
    S_CUNM     = 15'h2000,
    S_SEMIT    = 15'h4000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Input transfers are taken only between items.
  assign in_stall = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.addr_sel = ort_pkg::ADDR_IDX;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in   = 1'b1;
          cmd.slot_clr = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.req)
          ort_pkg::REQ_ISSUE:    state_next = S_ISCAN;
          ort_pkg::REQ_COMPLETE: state_next = S_CSCAN;
          ort_pkg::REQ_STAT: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = ort_pkg::ADDR_QUERY;
            state_next   = S_SEMIT;
          end
          default:               state_next = S_IDLE;
        endcase
      end
      S_ISCAN: begin
        if (sts.slot_end_issue) begin
          state_next = S_IDONE;
        end else if (sts.slot_valid) begin
          cmd.slot_inc = 1'b1;
        end else begin
          cmd.idx_init = 1'b1;
          state_next   = S_IREDUCE;
        end
      end
      S_IREDUCE: begin
        if (sts.j_end) begin
          state_next = S_IDONE;
        end else if (sts.idx_ge_nt) begin
          cmd.idx_reduce = 1'b1;
        end else begin
          state_next = S_IRD;
        end
      end
      S_IRD: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ort_pkg::ADDR_IDX;
        state_next   = S_ICHK;
      end
      S_ICHK: begin
        if (sts.qualifies) begin
          state_next = S_IEMIT;
        end else begin
          cmd.idx_step = 1'b1;
          state_next   = S_IREDUCE;
        end
      end
      S_IEMIT: begin
        if (sts.can_emit) begin
          cmd.issue_commit = 1'b1;
          cmd.slot_inc     = 1'b1;
          state_next       = S_ISCAN;
        end
      end
      S_IDONE: begin
        if (sts.can_emit) begin
          cmd.out_done = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_CSCAN: begin
        if (sts.slot_end_all) begin
          state_next = S_CUNM;
        end else if (sts.slot_valid && sts.tid_match) begin
          cmd.mem_rd   = 1'b1;
          cmd.addr_sel = ort_pkg::ADDR_SLOT;
          state_next   = S_CUPD;
        end else begin
          cmd.slot_inc = 1'b1;
        end
      end
      S_CUPD: begin
        cmd.comp_update = 1'b1;
        state_next      = S_CDIVST;
      end
      S_CDIVST: begin
        cmd.div_start = 1'b1;
        state_next    = S_CDIV;
      end
      S_CDIV: begin
        if (sts.div_done) begin
          state_next = S_CEMIT;
        end
      end
      S_CEMIT: begin
        if (sts.can_emit) begin
          cmd.comp_commit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_CUNM: begin
        if (sts.can_emit) begin
          cmd.out_unmatched = 1'b1;
          state_next        = S_IDLE;
        end
      end
      S_SEMIT: begin
        if (sts.can_emit) begin
          cmd.out_stat = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/core/ort_dp.sv
// ----------------------------------------------------------------------------
// ort_dp: datapath of the outstanding request tracker
// Slot table, target statistics memory, counters, divider and result register.
// ----------------------------------------------------------------------------
module ort_dp #(
  parameter int SLOTS   = ort_pkg::SLOTS_DEF,
  parameter int TARGETS = ort_pkg::TARGETS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [6:0]    cfg_data,
  input  logic [1:0]    req_type,
  input  logic [31:0]   now_us,
  input  logic [31:0]   resp_tid,
  input  logic [1:0]    resp_status,
  input  logic [5:0]    query_target,
  input  logic [2:0]    stat_select,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    kind,
  output logic          last,
  output logic [3:0]    slot_index,
  output logic [5:0]    target_index,
  output logic [31:0]   out_tid,
  output logic [31:0]   latency_us,
  output logic [31:0]   stat_value,
  input  ort_pkg::cmd_t cmd,
  output ort_pkg::sts_t sts
);

  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCW = $clog2(SLOTS + 1);
  localparam int TW  = (TARGETS > 1) ? $clog2(TARGETS) : 1;
  localparam int NTW = $clog2(TARGETS + 1);

  // Configuration registers.
  logic [4:0] slot_count;
  logic [4:0] per_target_limit;
  logic [6:0] target_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count       <= 5'd1;
      per_target_limit <= 5'd1;
      target_count     <= 7'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ort_pkg::CFG_SLOT_COUNT:   slot_count       <= cfg_data[4:0];
        ort_pkg::CFG_TARGET_LIMIT: per_target_limit <= cfg_data[4:0];
        ort_pkg::CFG_TARGET_COUNT: target_count     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective slot and target counts, limited to the built sizes.
  logic [SCW-1:0] ns;
  logic [NTW-1:0] nt;
  assign ns = (32'(slot_count) < 32'(SLOTS)) ? SCW'(slot_count) : SCW'(SLOTS);
  assign nt = (32'(target_count) < 32'(TARGETS)) ? NTW'(target_count) : NTW'(TARGETS);

  // Captured input item.
  ort_pkg::req_t req_q;
  logic [31:0]   now_q;
  logic [31:0]   tid_in_q;
  logic [1:0]    status_q;
  logic [5:0]    qt_q;
  logic [2:0]    sel_q;

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      req_q    <= ort_pkg::req_t'(req_type);
      now_q    <= now_us;
      tid_in_q <= resp_tid;
      status_q <= resp_status;
      qt_q     <= query_target;
      sel_q    <= stat_select;
    end
  end

  // Slot table.
  logic          slot_valid [SLOTS];
  logic [31:0]   slot_tid   [SLOTS];
  logic [TW-1:0] slot_tgt   [SLOTS];
  logic [31:0]   slot_start [SLOTS];

  // Scan counters and round-robin state.
  logic [SCW-1:0] slot_ctr;
  logic [SCW-1:0] issued;
  logic [NTW-1:0] idx;
  logic [NTW-1:0] j;
  logic [TW-1:0]  last_tgt;
  logic [31:0]    next_tid;
  logic [SW-1:0]  si;

  assign si = slot_ctr[SW-1:0];

  // Target memory and its valid bits.
  ort_pkg::rec_t mem [TARGETS];
  logic          tvalid [TARGETS];
  ort_pkg::rec_t rd_q;
  logic          rd_vld_q;
  ort_pkg::rec_t eff;
  logic [TW-1:0] raddr;
  logic          mem_we;
  logic [TW-1:0] waddr;
  ort_pkg::rec_t wdata;

  // Completion working registers.
  ort_pkg::rec_t upd_q;
  logic [31:0]   lat_q;
  logic [TW-1:0] ctgt_q;
  logic [SW-1:0] cslot_q;

  // Divider.
  logic        div_done;
  logic [63:0] div_q;
  logic [33:0] div_cnt;
  logic [31:0] avg_sat;

  // A target never written reads as an all-zero record.
  assign eff = rd_vld_q ? rd_q : '0;

  // Read address selection.
  always_comb begin
    case (cmd.addr_sel)
      ort_pkg::ADDR_SLOT:  raddr = slot_tgt[si];
      ort_pkg::ADDR_QUERY: raddr = TW'(qt_q);
      default:             raddr = idx[TW-1:0];
    endcase
  end

  // Record written on an issue or at the end of a completion.
  always_comb begin
    if (cmd.issue_commit) begin
      mem_we = 1'b1;
      waddr  = idx[TW-1:0];
      wdata  = eff;
      wdata.outs = (eff.outs < ort_pkg::OUTS_MAX) ? eff.outs + 5'd1 : eff.outs;
      wdata.sent = ort_pkg::sat_inc32(eff.sent);
    end else begin
      mem_we    = cmd.comp_commit;
      waddr     = ctgt_q;
      wdata     = upd_q;
      wdata.avg = avg_sat;
    end
  end

  // Target memory ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TARGETS; k++) begin
        tvalid[k] <= 1'b0;
      end
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        tvalid[waddr] <= 1'b1;
      end
      if (cmd.mem_rd) begin
        rd_vld_q <= tvalid[raddr];
      end
    end
  end

  // Slot valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SLOTS; k++) begin
        slot_valid[k] <= 1'b0;
      end
    end else if (cmd.issue_commit) begin
      slot_valid[si] <= 1'b1;
    end else if (cmd.comp_update) begin
      slot_valid[si] <= 1'b0;
    end
  end

  // Slot contents, written on issue.
  always_ff @(posedge clk) begin
    if (cmd.issue_commit) begin
      slot_tid[si]   <= next_tid;
      slot_tgt[si]   <= idx[TW-1:0];
      slot_start[si] <= now_q;
    end
  end

  // Counters and round-robin pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ctr <= '0;
      issued   <= '0;
      idx      <= '0;
      j        <= '0;
      last_tgt <= '0;
      next_tid <= ort_pkg::TID_RESET;
    end else begin
      if (cmd.slot_clr) begin
        slot_ctr <= '0;
        issued   <= '0;
      end else if (cmd.slot_inc) begin
        slot_ctr <= slot_ctr + SCW'(1);
      end
      if (cmd.idx_init) begin
        idx <= NTW'(last_tgt) + NTW'(1);
        j   <= '0;
      end else if (cmd.idx_reduce) begin
        idx <= idx - nt;
      end else if (cmd.idx_step) begin
        idx <= (idx + NTW'(1) == nt) ? '0 : idx + NTW'(1);
        j   <= j + NTW'(1);
      end
      if (cmd.issue_commit) begin
        last_tgt <= idx[TW-1:0];
        next_tid <= next_tid + 32'd1;
        issued   <= issued + SCW'(1);
      end
    end
  end

  // Statistics update of a matched completion.
  logic [31:0]   lat_now;
  logic [64:0]   total_sum;
  ort_pkg::rec_t upd_next;
  assign lat_now   = now_q - slot_start[si];
  assign total_sum = {1'b0, eff.total} + {33'd0, lat_now};

  always_comb begin
    upd_next      = eff;
    upd_next.outs = (eff.outs != 5'd0) ? eff.outs - 5'd1 : eff.outs;
    if (status_q == ort_pkg::ST_OK) begin
      upd_next.ok = ort_pkg::sat_inc32(eff.ok);
    end else if (status_q == ort_pkg::ST_TIMEOUT) begin
      upd_next.tmo = ort_pkg::sat_inc32(eff.tmo);
    end else begin
      upd_next.err = ort_pkg::sat_inc32(eff.err);
    end
    if (lat_now > eff.max_lat) begin
      upd_next.max_lat = lat_now;
    end
    if (lat_now < eff.min_lat || eff.min_lat == 32'd0) begin
      upd_next.min_lat = lat_now;
    end
    upd_next.total = total_sum[64] ? {64{1'b1}} : total_sum[63:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.comp_update) begin
      upd_q   <= upd_next;
      lat_q   <= lat_now;
      ctgt_q  <= slot_tgt[si];
      cslot_q <= si;
    end
  end

  // Average latency: total over all completions, held to 32 bits.
  assign div_cnt = 34'(upd_q.ok) + 34'(upd_q.tmo) + 34'(upd_q.err);
  assign avg_sat = (div_q[63:32] != 32'd0) ? ort_pkg::M32 : div_q[31:0];

  ort_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (upd_q.total),
    .divisor  (div_cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  // Selected statistic of a read.
  logic [31:0] stat_sel;
  always_comb begin
    case (sel_q)
      ort_pkg::SEL_SENT:    stat_sel = eff.sent;
      ort_pkg::SEL_OK:      stat_sel = eff.ok;
      ort_pkg::SEL_TIMEOUT: stat_sel = eff.tmo;
      ort_pkg::SEL_ERROR:   stat_sel = eff.err;
      ort_pkg::SEL_MIN:     stat_sel = eff.min_lat;
      ort_pkg::SEL_MAX:     stat_sel = eff.max_lat;
      ort_pkg::SEL_AVG:     stat_sel = eff.avg;
      default:              stat_sel = 32'd0;
    endcase
    if (32'(qt_q) >= 32'(TARGETS)) begin
      stat_sel = 32'd0;
    end
  end

  // Result register; a new result loads once the previous one has transferred.
  logic can_emit;
  assign can_emit = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.issue_commit || cmd.comp_commit || cmd.out_unmatched ||
                 cmd.out_done || cmd.out_stat) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue_commit) begin
      kind         <= ort_pkg::KIND_ISSUED;
      last         <= 1'b0;
      slot_index   <= 4'(slot_ctr);
      target_index <= 6'(idx);
      out_tid      <= next_tid;
      latency_us   <= 32'd0;
      stat_value   <= 32'd0;
    end else if (cmd.comp_commit) begin
      kind         <= ort_pkg::KIND_MATCHED;
      last         <= 1'b1;
      slot_index   <= 4'(cslot_q);
      target_index <= 6'(ctgt_q);
      out_tid      <= tid_in_q;
      latency_us   <= lat_q;
      stat_value   <= 32'd0;
    end else if (cmd.out_unmatched) begin
      kind         <= ort_pkg::KIND_UNMATCHED;
      last         <= 1'b1;
      slot_index   <= 4'd0;
      target_index <= 6'd0;
      out_tid      <= tid_in_q;
      latency_us   <= 32'd0;
      stat_value   <= 32'd0;
    end else if (cmd.out_done) begin
      kind         <= ort_pkg::KIND_DONE;
      last         <= 1'b1;
      slot_index   <= 4'd0;
      target_index <= 6'd0;
      out_tid      <= 32'd0;
      latency_us   <= 32'd0;
      stat_value   <= 32'(issued);
    end else if (cmd.out_stat) begin
      kind         <= ort_pkg::KIND_STAT;
      last         <= 1'b1;
      slot_index   <= 4'd0;
      target_index <= qt_q;
      out_tid      <= 32'd0;
      latency_us   <= 32'd0;
      stat_value   <= stat_sel;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.req            = req_q;
    sts.slot_end_issue = (slot_ctr == ns);
    sts.slot_end_all   = (slot_ctr == SCW'(SLOTS));
    sts.slot_valid     = slot_valid[si];
    sts.tid_match      = (slot_tid[si] == tid_in_q);
    sts.idx_ge_nt      = (idx >= nt);
    sts.j_end          = (j == nt);
    sts.qualifies      = (eff.outs < per_target_limit);
    sts.div_done       = div_done;
    sts.can_emit       = can_emit;
  end

endmodule

### rtl/core/outstanding_request_tracker.sv
// ----------------------------------------------------------------------------
// outstanding_request_tracker: slot table of outstanding requests
// Issues requests round-robin under a per-target limit, matches completions
// and keeps per-target statistics.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Payload
// config    in         cfg_write             cfg_index, cfg_data
// request   in         in_valid / in_stall   req_type .. stat_select
// result    out        out_valid / out_stall kind .. stat_value
//
// One item at a time. A completion scans the slots one per cycle, then
// waits on the one-bit-per-cycle divider that forms the average. An issue
// pass steps over occupied slots and, for each free slot, tests targets
// round-robin against the per-target limit until one qualifies or none do.
// Reset is synchronous and clears all statistics at once through per-target
// valid bits. A stalled result holds the block at its next result.
//
module outstanding_request_tracker #(
  parameter int SLOTS   = ort_pkg::SLOTS_DEF,
  parameter int TARGETS = ort_pkg::TARGETS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] now_us,
  input  logic [31:0] resp_tid,
  input  logic [1:0]  resp_status,
  input  logic [5:0]  query_target,
  input  logic [2:0]  stat_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic        last,
  output logic [3:0]  slot_index,
  output logic [5:0]  target_index,
  output logic [31:0] out_tid,
  output logic [31:0] latency_us,
  output logic [31:0] stat_value
);

  ort_pkg::cmd_t cmd;
  ort_pkg::sts_t sts;

  // Sequencer.
  ort_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  ort_dp #(
    .SLOTS   (SLOTS),
    .TARGETS (TARGETS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .now_us       (now_us),
    .resp_tid     (resp_tid),
    .resp_status  (resp_status),
    .query_target (query_target),
    .stat_select  (stat_select),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .last         (last),
    .slot_index   (slot_index),
    .target_index (target_index),
    .out_tid      (out_tid),
    .latency_us   (latency_us),
    .stat_value   (stat_value),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
